FILE: sv/c128_pkg.sv
// Shared types, constants and symbol pattern table of the Code 128 symbol encoder.
package c128_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_CODE_SET     = 2'd0;
  localparam logic [1:0] REG_ADD_CHECKSUM = 2'd1;
  localparam logic [1:0] REG_EMIT_START   = 2'd2;
  localparam logic [1:0] REG_ESCAPE_CHAR  = 2'd3;

  // Character set codes.
  localparam logic [1:0] SET_A = 2'd0;
  localparam logic [1:0] SET_B = 2'd1;
  localparam logic [1:0] SET_C = 2'd2;

  // Special symbol values.
  localparam logic [6:0] SYM_FNC3    = 7'd96;
  localparam logic [6:0] SYM_FNC2    = 7'd97;
  localparam logic [6:0] SYM_FNC1    = 7'd102;
  localparam logic [6:0] SYM_FNC4_A  = 7'd101;
  localparam logic [6:0] SYM_FNC4_B  = 7'd100;
  localparam logic [6:0] SYM_DEL_B   = 7'd95;
  localparam logic [6:0] SYM_START_A = 7'd103;
  localparam logic [6:0] SYM_STOP    = 7'd106;
  localparam logic [6:0] SYM_TERM    = 7'd107;
  localparam logic [6:0] SYM_LAST    = 7'd105;

  // Characters that matter to the classifier.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TOP_A   = 8'h5F;
  localparam logic [7:0] CH_TOP_B   = 8'h7E;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_1       = 8'h31;
  localparam logic [7:0] CH_2       = 8'h32;
  localparam logic [7:0] CH_3       = 8'h33;
  localparam logic [7:0] CH_4       = 8'h34;
  localparam logic [7:0] CH_5       = 8'h35;
  localparam logic [7:0] CH_9       = 8'h39;

  // Width counts and fixed width words.
  localparam logic [2:0]  CNT_SYM     = 3'd6;
  localparam logic [2:0]  CNT_STOP    = 3'd7;
  localparam logic [2:0]  CNT_TERM    = 3'd1;
  localparam logic [27:0] STOP_DIGITS = 28'h2331112;
  localparam logic [20:0] TERM_WIDTHS = 21'd2;

  // Check symbol modulus and twice its value.
  localparam logic [7:0] MOD_1X = 8'd103;
  localparam logic [7:0] MOD_2X = 8'd206;

  // Bar and space widths of symbols 0..105, one hex digit per module width,
  // first width in the top digit.
  localparam logic [23:0] SYM_DIGITS [0:105] = '{
    24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322, 24'h131222,
    24'h122213, 24'h122312, 24'h132212, 24'h221213, 24'h221312, 24'h231212,
    24'h112232, 24'h122132, 24'h122231, 24'h113222, 24'h123122, 24'h123221,
    24'h223211, 24'h221132, 24'h221231, 24'h213212, 24'h223112, 24'h312131,
    24'h311222, 24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
    24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123, 24'h131321,
    24'h112313, 24'h132113, 24'h132311, 24'h211313, 24'h231113, 24'h231311,
    24'h112133, 24'h112331, 24'h132131, 24'h113123, 24'h113321, 24'h133121,
    24'h313121, 24'h211331, 24'h231131, 24'h213113, 24'h213311, 24'h213131,
    24'h311123, 24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
    24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422, 24'h121124,
    24'h121421, 24'h141122, 24'h141221, 24'h112214, 24'h112412, 24'h122114,
    24'h122411, 24'h142112, 24'h142211, 24'h241211, 24'h221114, 24'h413111,
    24'h241112, 24'h134111, 24'h111242, 24'h121142, 24'h121241, 24'h114212,
    24'h124112, 24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
    24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141, 24'h114113,
    24'h114311, 24'h411113, 24'h411311, 24'h113141, 24'h114131, 24'h311141,
    24'h411131, 24'h211412, 24'h211214, 24'h211232
  };

  // One item of work handed from the classifier to the symbol sequencer.
  typedef struct packed {
    logic       clr;
    logic       start;
    logic [6:0] start_val;
    logic       have;
    logic [6:0] val;
    logic       last;
    logic       check;
    logic       err;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // Operations still owed for the item in the sequencer.
  typedef struct packed {
    logic clr;
    logic err;
    logic start;
    logic data;
    logic check;
    logic stop;
    logic term;
  } work_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ERROR,
    OP_START,
    OP_DATA,
    OP_CHECK,
    OP_STOP,
    OP_TERM
  } op_t;

  // Packs seven hex digits, first in the top digit, into 3-bit widths with
  // the first width in the low bits.
  function automatic logic [20:0] digits_to_widths(logic [27:0] digs);
    logic [20:0] w;
    w = '0;
    for (int i = 0; i < 7; i++) begin
      w[3*i +: 3] = digs[4*(6-i) +: 3];
    end
    return w;
  endfunction

  function automatic logic [20:0] sym_widths(logic [6:0] v);
    logic [20:0] w;
    w = '0;
    if (v <= SYM_LAST) begin
      w = digits_to_widths({SYM_DIGITS[v], 4'h0});
    end
    return w;
  endfunction

endpackage

FILE: sv/c128_ifs.sv
// Handshake channels of the Code 128 symbol encoder: characters, symbols, configuration.
interface c128_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_char;
  logic       first_char;
  logic       last_char;
  logic       odd_length;

  modport source (output valid, data_char, first_char, last_char, odd_length, input ready);
  modport sink (input valid, data_char, first_char, last_char, odd_length, output ready);
endinterface

interface c128_sym_if;
  logic        valid;
  logic        ready;
  logic [6:0]  symbol_value;
  logic [20:0] bar_widths;
  logic [2:0]  width_count;
  logic        error_flag;
  logic        end_of_symbol;

  modport source (output valid, symbol_value, bar_widths, width_count, error_flag,
                  end_of_symbol, input ready);
  modport sink (input valid, symbol_value, bar_widths, width_count, error_flag,
                end_of_symbol, output ready);
endinterface

interface c128_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [6:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface

FILE: sv/c128_front.sv
// Character classifier: configuration registers, escape and digit state, work items.
module c128_front (
  input  logic                clk,
  input  logic                rst,
  c128_char_if.sink           chars,
  c128_cfg_if.sink            cfg,
  input  logic                q_full,
  output c128_pkg::push_t     push
);

  logic [1:0] code_set;
  logic       add_checksum;
  logic       emit_start;
  logic [6:0] escape_char;

  logic [3:0] held_digit;
  logic       digit_held;
  logic       escape_pending;
  logic       string_failed;

  logic       accept;
  logic [7:0] c;
  logic       first;
  logic       last;
  logic [3:0] eff_held;
  logic       eff_dh;
  logic       eff_esc;
  logic       failed;
  logic [7:0] hi;
  logic       bad;
  logic       have;
  logic [6:0] val;
  logic       esc_next;
  logic       dh_next;
  logic [3:0] held_next;

  assign cfg.ready   = 1'b1;
  assign chars.ready = !q_full;
  assign accept      = chars.valid && chars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_set     <= c128_pkg::SET_C;
      add_checksum <= 1'b1;
      emit_start   <= 1'b1;
      escape_char  <= 7'd92;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        c128_pkg::REG_CODE_SET:     code_set     <= cfg.wdata[1:0];
        c128_pkg::REG_ADD_CHECKSUM: add_checksum <= cfg.wdata[0];
        c128_pkg::REG_EMIT_START:   emit_start   <= cfg.wdata[0];
        c128_pkg::REG_ESCAPE_CHAR:  escape_char  <= cfg.wdata;
      endcase
    end
  end

  assign c        = chars.data_char;
  assign first    = chars.first_char;
  assign last     = chars.last_char;
  assign eff_held = first ? 4'd0 : held_digit;
  assign eff_dh   = !first && digit_held;
  assign eff_esc  = !first && escape_pending;
  assign failed   = !first && string_failed;
  assign hi       = (code_set == c128_pkg::SET_A) ? c128_pkg::CH_TOP_A : c128_pkg::CH_TOP_B;

  always_comb begin
    bad       = 1'b0;
    have      = 1'b0;
    val       = '0;
    esc_next  = eff_esc;
    dh_next   = eff_dh;
    held_next = eff_held;
    unique case (code_set)
      c128_pkg::SET_A, c128_pkg::SET_B: begin
        if (c < c128_pkg::CH_SPACE || c > hi) begin
          bad = 1'b1;
        end else if (eff_esc) begin
          esc_next = 1'b0;
          have     = 1'b1;
          priority if (c == c128_pkg::CH_0) begin
            val = escape_char - 7'h20;
          end else if (c == c128_pkg::CH_1) begin
            val = c128_pkg::SYM_FNC1;
          end else if (c == c128_pkg::CH_2) begin
            val = c128_pkg::SYM_FNC2;
          end else if (c == c128_pkg::CH_3) begin
            val = c128_pkg::SYM_FNC3;
          end else if (c == c128_pkg::CH_4) begin
            val = (code_set == c128_pkg::SET_A) ? c128_pkg::SYM_FNC4_A : c128_pkg::SYM_FNC4_B;
          end else if (c == c128_pkg::CH_5 && code_set == c128_pkg::SET_B) begin
            val = c128_pkg::SYM_DEL_B;
          end else if (code_set == c128_pkg::SET_A && c >= c128_pkg::CH_AT) begin
            // Control characters of set A: the follower's own code.
            val = c[6:0];
          end else begin
            have = 1'b0;
            bad  = 1'b1;
          end
        end else if (c == {1'b0, escape_char}) begin
          esc_next = 1'b1;
        end else begin
          val  = c[6:0] - 7'h20;
          have = 1'b1;
        end
      end
      c128_pkg::SET_C: begin
        if (c < c128_pkg::CH_0 || c > c128_pkg::CH_9) begin
          bad = 1'b1;
        end else if (first && chars.odd_length) begin
          val  = {3'b000, c[3:0]};
          have = 1'b1;
        end else if (eff_dh) begin
          val       = {eff_held, 3'b000} + {2'b00, eff_held, 1'b0} + {3'b000, c[3:0]};
          have      = 1'b1;
          dh_next   = 1'b0;
          held_next = 4'd0;
        end else begin
          held_next = c[3:0];
          dh_next   = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
    // A string may not end inside an escape pair or a digit pair.
    if (!bad && last && (esc_next || dh_next)) begin
      bad = 1'b1;
    end
  end

  always_comb begin
    push.valid           = accept && !failed && (bad || first || have || last);
    push.entry.err       = bad;
    push.entry.clr       = !bad && first;
    push.entry.start     = !bad && first && emit_start;
    push.entry.start_val = c128_pkg::SYM_START_A + {5'b00000, code_set};
    push.entry.have      = !bad && have;
    push.entry.val       = val;
    push.entry.last      = !bad && last;
    push.entry.check     = add_checksum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_digit     <= 4'd0;
      digit_held     <= 1'b0;
      escape_pending <= 1'b0;
      string_failed  <= 1'b0;
    end else if (accept) begin
      if (failed) begin
        if (last) begin
          string_failed <= 1'b0;
        end
      end else if (bad || last) begin
        held_digit     <= 4'd0;
        digit_held     <= 1'b0;
        escape_pending <= 1'b0;
        string_failed  <= bad && !last;
      end else begin
        held_digit     <= held_next;
        digit_held     <= dh_next;
        escape_pending <= esc_next;
        string_failed  <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/c128_queue.sv
// Work item queue between the classifier and the symbol sequencer.
module c128_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  c128_pkg::push_t  push,
  input  logic             pop,
  output c128_pkg::entry_t head,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  c128_pkg::entry_t mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push.valid) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/c128_back.sv
// Symbol sequencer: emits start, data, check, stop, terminator and error symbols and keeps the check sum.
module c128_back (
  input  logic             clk,
  input  logic             rst,
  input  c128_pkg::entry_t head,
  input  logic             q_empty,
  output logic             pop,
  c128_sym_if.source       symbols
);

  c128_pkg::work_t pend;
  c128_pkg::work_t left;
  c128_pkg::op_t   op;
  logic [6:0]      cur_start_val;
  logic [6:0]      cur_val;

  logic        ov;
  logic        out_free;
  logic        need_out;
  logic        need_idle;
  logic        fire;
  logic        pipe_idle;
  logic        wpush;
  logic        wclear;
  logic [6:0]  sv;
  logic [6:0]  o_sym;
  logic [20:0] o_widths;
  logic [2:0]  o_cnt;
  logic        o_err;
  logic        o_eos;

  // Check sum pipeline: product, three folds of 128 = 25 (mod 103), accumulate.
  logic [6:0]  weight_index;
  logic [6:0]  wm;
  logic [6:0]  check_sum;
  logic        pv0;
  logic        pv1;
  logic        pv2;
  logic [13:0] prod;
  logic [11:0] fold1;
  logic [9:0]  fold2;
  logic [7:0]  fold3;
  logic [7:0]  fold3_q;
  logic [7:0]  resid;
  logic [7:0]  acc;

  always_comb begin
    priority if (pend.clr) begin
      op = c128_pkg::OP_CLEAR;
    end else if (pend.err) begin
      op = c128_pkg::OP_ERROR;
    end else if (pend.start) begin
      op = c128_pkg::OP_START;
    end else if (pend.data) begin
      op = c128_pkg::OP_DATA;
    end else if (pend.check) begin
      op = c128_pkg::OP_CHECK;
    end else if (pend.stop) begin
      op = c128_pkg::OP_STOP;
    end else if (pend.term) begin
      op = c128_pkg::OP_TERM;
    end else begin
      op = c128_pkg::OP_NONE;
    end
  end

  always_comb begin
    left      = pend;
    need_out  = 1'b1;
    need_idle = 1'b0;
    sv        = check_sum;
    o_sym     = '0;
    o_widths  = '0;
    o_cnt     = '0;
    o_err     = 1'b0;
    o_eos     = 1'b0;
    unique case (op)
      c128_pkg::OP_NONE: begin
        need_out = 1'b0;
      end
      c128_pkg::OP_CLEAR: begin
        left.clr  = 1'b0;
        need_out  = 1'b0;
        need_idle = 1'b1;
      end
      c128_pkg::OP_ERROR: begin
        left.err  = 1'b0;
        need_idle = 1'b1;
        o_err     = 1'b1;
        o_eos     = 1'b1;
      end
      c128_pkg::OP_START: begin
        left.start = 1'b0;
        sv         = cur_start_val;
        o_sym      = sv;
        o_widths   = c128_pkg::sym_widths(sv);
        o_cnt      = c128_pkg::CNT_SYM;
      end
      c128_pkg::OP_DATA: begin
        left.data = 1'b0;
        sv        = cur_val;
        o_sym     = sv;
        o_widths  = c128_pkg::sym_widths(sv);
        o_cnt     = c128_pkg::CNT_SYM;
      end
      c128_pkg::OP_CHECK: begin
        left.check = 1'b0;
        need_idle  = 1'b1;
        o_sym      = sv;
        o_widths   = c128_pkg::sym_widths(sv);
        o_cnt      = c128_pkg::CNT_SYM;
      end
      c128_pkg::OP_STOP: begin
        left.stop = 1'b0;
        o_sym     = c128_pkg::SYM_STOP;
        o_widths  = c128_pkg::digits_to_widths(c128_pkg::STOP_DIGITS);
        o_cnt     = c128_pkg::CNT_STOP;
      end
      c128_pkg::OP_TERM: begin
        left.term = 1'b0;
        need_idle = 1'b1;
        o_sym     = c128_pkg::SYM_TERM;
        o_widths  = c128_pkg::TERM_WIDTHS;
        o_cnt     = c128_pkg::CNT_TERM;
        o_eos     = 1'b1;
      end
    endcase
  end

  assign out_free  = !ov || symbols.ready;
  assign pipe_idle = !pv0 && !pv1 && !pv2;
  assign fire      = (op != c128_pkg::OP_NONE) && (!need_out || out_free)
                     && (!need_idle || pipe_idle);
  assign pop       = !q_empty && ((op == c128_pkg::OP_NONE) || (fire && (left == '0)));
  assign wpush     = fire && (op == c128_pkg::OP_START || op == c128_pkg::OP_DATA);
  assign wclear    = fire && (op == c128_pkg::OP_CLEAR || op == c128_pkg::OP_TERM
                              || op == c128_pkg::OP_ERROR);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (pop) begin
      pend.clr   <= head.clr;
      pend.err   <= head.err;
      pend.start <= head.start;
      pend.data  <= head.have;
      pend.check <= head.last && head.check;
      pend.stop  <= head.last;
      pend.term  <= head.last;
    end else if (fire) begin
      pend <= left;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_start_val <= head.start_val;
      cur_val       <= head.val;
    end
  end

  // Output register: a new symbol is loaded only while the register is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (fire && need_out) begin
      ov <= 1'b1;
    end else if (symbols.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && need_out) begin
      symbols.symbol_value  <= o_sym;
      symbols.bar_widths    <= o_widths;
      symbols.width_count   <= o_cnt;
      symbols.error_flag    <= o_err;
      symbols.end_of_symbol <= o_eos;
    end
  end

  assign symbols.valid = ov;

  // Weight of the symbol going out, reduced modulo 103.
  always_comb begin
    if (weight_index == 7'd0) begin
      wm = 7'd1;
    end else if (weight_index == c128_pkg::MOD_1X[6:0]) begin
      wm = 7'd0;
    end else begin
      wm = weight_index;
    end
  end

  assign fold2 = 10'({fold1[11:7], 4'b0000}) + 10'({fold1[11:7], 3'b000})
                 + 10'(fold1[11:7]) + 10'(fold1[6:0]);
  assign fold3 = 8'({fold2[9:7], 4'b0000}) + 8'({fold2[9:7], 3'b000})
                 + 8'(fold2[9:7]) + 8'(fold2[6:0]);

  always_comb begin
    if (fold3_q >= c128_pkg::MOD_2X) begin
      resid = fold3_q - c128_pkg::MOD_2X;
    end else if (fold3_q >= c128_pkg::MOD_1X) begin
      resid = fold3_q - c128_pkg::MOD_1X;
    end else begin
      resid = fold3_q;
    end
    acc = {1'b0, check_sum} + resid;
  end

  always_ff @(posedge clk) begin
    prod    <= 14'(sv) * 14'(wm);
    fold1   <= 12'({prod[13:7], 4'b0000}) + 12'({prod[13:7], 3'b000})
               + 12'(prod[13:7]) + 12'(prod[6:0]);
    fold3_q <= fold3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv0          <= 1'b0;
      pv1          <= 1'b0;
      pv2          <= 1'b0;
      weight_index <= 7'd0;
      check_sum    <= 7'd0;
    end else begin
      pv0 <= wpush;
      pv1 <= pv0;
      pv2 <= pv1;
      if (wclear) begin
        weight_index <= 7'd0;
        check_sum    <= 7'd0;
      end else begin
        if (wpush) begin
          weight_index <= (weight_index == 7'd0 || weight_index >= c128_pkg::MOD_1X[6:0])
                          ? 7'd1 : weight_index + 7'd1;
        end
        if (pv2) begin
          check_sum <= (acc >= c128_pkg::MOD_1X) ? 7'(acc - c128_pkg::MOD_1X) : acc[6:0];
        end
      end
    end
  end

endmodule

FILE: sv/code128_symbol_encoder.sv
// Top level of the Code 128 symbol encoder: classifier, work queue and symbol sequencer.
//
//   Port      Direction  Carries
//   chars     in         data_char, first_char, last_char, odd_length
//   symbols   out        symbol_value, bar_widths, width_count, error_flag, end_of_symbol
//   cfg       in         addr (register index), wdata
//
// A character is taken whenever the work queue has room.
// The sequencer sends one symbol per cycle while the output is not stalled and no
// step waits for the check sum pipeline; a first character may also clear the string
// and send a start symbol, a last character may add the check, stop and terminator
// symbols. The check, terminator, error and string clear steps first wait for the
// three stage check sum pipeline to drain. A stalled symbol output holds the
// sequencer while the queue keeps taking characters until it fills.
module code128_symbol_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  c128_char_if.sink   chars,
  c128_sym_if.source  symbols,
  c128_cfg_if.sink    cfg
);

  c128_pkg::push_t  push;
  c128_pkg::entry_t head;
  logic             q_full;
  logic             q_empty;
  logic             pop;

  c128_front u_front (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push)
  );

  c128_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  c128_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .symbols (symbols)
  );

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    symbols.valid && symbols.error_flag |->
      symbols.end_of_symbol && symbols.width_count == 3'd0 && symbols.symbol_value == 7'd0)
    else $error("error item carries symbol data");

  a_end_marks: assert property (@(posedge clk) disable iff (rst)
    symbols.valid && symbols.end_of_symbol |->
      symbols.error_flag || symbols.symbol_value == c128_pkg::SYM_TERM)
    else $error("end of symbol on an item that is neither terminator nor error");

  a_stop_then_term: assert property (@(posedge clk) disable iff (rst)
    symbols.valid && symbols.ready && symbols.symbol_value == c128_pkg::SYM_STOP |=>
      !symbols.valid || symbols.symbol_value == c128_pkg::SYM_TERM)
    else $error("stop symbol not followed by the terminator");

  a_queue_flow: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && q_full) && !(pop && q_empty))
    else $error("work queue overflow or underflow");

endmodule

FILE: tb/tb.sv
// Self-checking testbench of the Code 128 symbol encoder with a built-in symbol predictor.
`timescale 1ns / 1ps

module tb;
  import c128_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE       = 24;
  localparam int LONG_HOLD    = 300;
  localparam int CHECK_MOD    = 103;

  localparam logic [1:0] SET_NONE  = 2'd3;
  localparam logic [7:0] BACKSLASH = 8'h5C;

  // Module widths of symbols 0..105, one hex digit per width, first width on top.
  localparam logic [23:0] BAR_PATTERNS [0:105] = '{
    24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322, 24'h131222, 24'h122213,
    24'h122312, 24'h132212, 24'h221213, 24'h221312, 24'h231212, 24'h112232, 24'h122132,
    24'h122231, 24'h113222, 24'h123122, 24'h123221, 24'h223211, 24'h221132, 24'h221231,
    24'h213212, 24'h223112, 24'h312131, 24'h311222, 24'h321122, 24'h321221, 24'h312212,
    24'h322112, 24'h322211, 24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123,
    24'h131321, 24'h112313, 24'h132113, 24'h132311, 24'h211313, 24'h231113, 24'h231311,
    24'h112133, 24'h112331, 24'h132131, 24'h113123, 24'h113321, 24'h133121, 24'h313121,
    24'h211331, 24'h231131, 24'h213113, 24'h213311, 24'h213131, 24'h311123, 24'h311321,
    24'h331121, 24'h312113, 24'h312311, 24'h332111, 24'h314111, 24'h221411, 24'h431111,
    24'h111224, 24'h111422, 24'h121124, 24'h121421, 24'h141122, 24'h141221, 24'h112214,
    24'h112412, 24'h122114, 24'h122411, 24'h142112, 24'h142211, 24'h241211, 24'h221114,
    24'h413111, 24'h241112, 24'h134111, 24'h111242, 24'h121142, 24'h121241, 24'h114212,
    24'h124112, 24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141, 24'h214121,
    24'h412121, 24'h111143, 24'h111341, 24'h131141, 24'h114113, 24'h114311, 24'h411113,
    24'h411311, 24'h113141, 24'h114131, 24'h311141, 24'h411131, 24'h211412, 24'h211214,
    24'h211232
  };
  // Stop widths 2 3 3 1 1 1 2, the last width in the top bits.
  localparam logic [20:0] STOP_BARS = {3'd2, 3'd1, 3'd1, 3'd1, 3'd3, 3'd3, 3'd2};
  localparam logic [20:0] TERM_BAR  = 21'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       first_char;
    logic       last_char;
    logic       odd_length;
  } char_t;

  typedef struct packed {
    logic [6:0]  sym;
    logic [20:0] bars;
    logic [2:0]  count;
    logic        err;
    logic        eos;
  } symbol_t;

  typedef enum logic [2:0] {JOB_CHAR, JOB_CFG, JOB_DRAIN, JOB_HOLD, JOB_CALM} job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    char_t      c;
    logic [1:0] reg_idx;
    logic [6:0] reg_val;
  } job_t;

  logic clk;
  logic rst;

  c128_char_if char_bus ();
  c128_sym_if  sym_bus ();
  c128_cfg_if  cfg_bus ();

  code128_symbol_encoder i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (char_bus),
    .symbols (sym_bus),
    .cfg     (cfg_bus)
  );

  job_t      jobs[$];
  symbol_t   owed_symbols[$];
  logic [7:0] word_buf[$];

  // Predictor copy of the registers and of the per-string state.
  logic [1:0] m_set;
  logic       m_check;
  logic       m_start;
  logic [6:0] m_escape;
  logic [6:0] chk_sum;
  logic [6:0] chk_weight;
  logic [3:0] held;
  logic       holding;
  logic       esc_pend;
  logic       failed;

  // What the stimulus generator believes the registers hold.
  logic [1:0] g_set;
  logic [6:0] g_esc;
  int         queued_chars = 0;

  logic  hold_req = 1'b0;
  logic  hold_ack = 1'b0;
  logic  calm = 1'b0;
  logic  all_sent = 1'b0;
  int    gap_left;
  int    settle_cnt;
  int    stall_left;
  logic  [15:0] rx_cycle;
  logic  char_on;
  logic  cfg_on;
  logic  rx_open;
  char_t cur_char;
  job_t  cur_cfg;
  job_t  cur_job;
  symbol_t want;

  int n_chars = 0;
  int n_writes = 0;
  int n_checked = 0;
  int n_err_seen = 0;
  int fail_count = 0;
  int cycle_cnt = 0;

  // ---------------------------------------------------------------- predictor

  function automatic logic [20:0] bars_of(logic [6:0] v);
    logic [20:0] w;
    w = '0;
    for (int i = 0; i < 6; i++) begin
      w[3*i +: 3] = BAR_PATTERNS[v][4*(5-i) +: 3];
    end
    return w;
  endfunction

  function automatic void owe(logic [6:0] s, logic [20:0] b, logic [2:0] n, bit e, bit x);
    symbol_t r;
    r.sym   = s;
    r.bars  = b;
    r.count = n;
    r.err   = e;
    r.eos   = x;
    owed_symbols.push_back(r);
  endfunction

  function automatic void clear_string();
    chk_sum    = '0;
    chk_weight = '0;
    held       = '0;
    holding    = 1'b0;
    esc_pend   = 1'b0;
    failed     = 1'b0;
  endfunction

  function automatic void add_weighted(logic [6:0] v);
    int w;
    w = (chk_weight == 0) ? 1 : chk_weight;
    chk_sum = (chk_sum + v * w) % CHECK_MOD;
    chk_weight = (chk_weight == 0 || chk_weight >= CHECK_MOD) ? 7'd1 : chk_weight + 7'd1;
    owe(v, bars_of(v), CNT_SYM, 1'b0, 1'b0);
  endfunction

  function automatic void load_register(logic [1:0] idx, logic [6:0] val);
    case (idx)
      REG_CODE_SET:     m_set    = val[1:0];
      REG_ADD_CHECKSUM: m_check  = val[0];
      REG_EMIT_START:   m_start  = val[0];
      REG_ESCAPE_CHAR:  m_escape = val;
      default: ;
    endcase
  endfunction

  function automatic void encode_char(char_t c);
    int val;
    int top;
    bit have;
    bit bad;
    have = 1'b0;
    bad  = 1'b0;
    val  = 0;
    if (c.first_char) clear_string();
    // After an invalid character the rest of the string is swallowed.
    if (failed) begin
      if (c.last_char) clear_string();
      return;
    end
    if (m_set == SET_A || m_set == SET_B) begin
      top = (m_set == SET_A) ? CH_TOP_A : CH_TOP_B;
      if (c.ch < CH_SPACE || c.ch > top) begin
        bad = 1'b1;
      end else if (esc_pend) begin
        esc_pend = 1'b0;
        have = 1'b1;
        if (c.ch == CH_0) val = m_escape - CH_SPACE;
        else if (c.ch == CH_1) val = SYM_FNC1;
        else if (c.ch == CH_2) val = SYM_FNC2;
        else if (c.ch == CH_3) val = SYM_FNC3;
        else if (c.ch == CH_4) val = (m_set == SET_A) ? SYM_FNC4_A : SYM_FNC4_B;
        else if (c.ch == CH_5 && m_set == SET_B) val = SYM_DEL_B;
        else if (m_set == SET_A && c.ch >= CH_AT) val = c.ch;
        else begin
          have = 1'b0;
          bad = 1'b1;
        end
      end else if (c.ch == {1'b0, m_escape}) begin
        esc_pend = 1'b1;
      end else begin
        val = c.ch - CH_SPACE;
        have = 1'b1;
      end
    end else if (m_set == SET_C) begin
      if (c.ch < CH_0 || c.ch > CH_9) begin
        bad = 1'b1;
      end else if (c.first_char && c.odd_length) begin
        val = c.ch - CH_0;
        have = 1'b1;
      end else if (holding) begin
        val = held * 10 + (c.ch - CH_0);
        have = 1'b1;
        holding = 1'b0;
        held = '0;
      end else begin
        held = c.ch - CH_0;
        holding = 1'b1;
      end
    end else begin
      bad = 1'b1;
    end

    if (!bad && c.last_char && (esc_pend || holding)) bad = 1'b1;

    if (bad) begin
      owe('0, '0, '0, 1'b1, 1'b1);
      clear_string();
      if (!c.last_char) failed = 1'b1;
      return;
    end

    if (c.first_char && m_start) add_weighted(SYM_START_A + m_set);
    if (have) add_weighted(val[6:0]);
    if (c.last_char) begin
      if (m_check) owe(chk_sum, bars_of(chk_sum), CNT_SYM, 1'b0, 1'b0);
      owe(SYM_STOP, STOP_BARS, CNT_STOP, 1'b0, 1'b0);
      owe(SYM_TERM, TERM_BAR, CNT_TERM, 1'b0, 1'b1);
      clear_string();
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void add_char(logic [7:0] ch, bit f, bit l, bit o);
    job_t j;
    j = '0;
    j.kind         = JOB_CHAR;
    j.c.ch         = ch;
    j.c.first_char = f;
    j.c.last_char  = l;
    j.c.odd_length = o;
    jobs.push_back(j);
    queued_chars++;
  endfunction

  function automatic void add_job(job_kind_t k, logic [1:0] idx, logic [6:0] val);
    job_t j;
    j = '0;
    j.kind    = k;
    j.reg_idx = idx;
    j.reg_val = val;
    jobs.push_back(j);
  endfunction

  // Registers change only once the block has gone quiet.
  function automatic void setup(logic [1:0] set, bit ck, bit st, logic [6:0] esc);
    add_job(JOB_DRAIN, '0, '0);
    add_job(JOB_CFG, REG_CODE_SET, {5'd0, set});
    add_job(JOB_CFG, REG_ADD_CHECKSUM, {6'd0, ck});
    add_job(JOB_CFG, REG_EMIT_START, {6'd0, st});
    add_job(JOB_CFG, REG_ESCAPE_CHAR, esc);
    g_set = set;
    g_esc = esc;
  endfunction

  function automatic logic [7:0] top_char();
    return (g_set == SET_A) ? CH_TOP_A : CH_TOP_B;
  endfunction

  function automatic bit esc_usable();
    return (g_set == SET_A && g_esc <= CH_TOP_A) || g_set == SET_B;
  endfunction

  function automatic bit char_ok(logic [7:0] ch);
    if (g_set == SET_C) return ch >= CH_0 && ch <= CH_9;
    if (g_set == SET_NONE) return 1'b0;
    return ch >= CH_SPACE && ch <= top_char();
  endfunction

  function automatic logic [7:0] gen_plain();
    logic [7:0] ch;
    if (g_set == SET_C) return $urandom_range(CH_0, CH_9);
    do ch = $urandom_range(CH_SPACE, top_char()); while (ch == {1'b0, g_esc});
    return ch;
  endfunction

  function automatic logic [7:0] gen_follow();
    if (g_set == SET_B) return $urandom_range(CH_0, CH_5);
    if ($urandom_range(0, 1) == 0) return $urandom_range(CH_0, CH_4);
    return $urandom_range(CH_AT, CH_TOP_A);
  endfunction

  // An in-range character that cannot follow the escape character.
  function automatic logic [7:0] gen_wrong_follow();
    logic [7:0] ch;
    do ch = $urandom_range(CH_SPACE, top_char());
    while ((ch >= CH_0 && ch <= ((g_set == SET_A) ? CH_4 : CH_5)) ||
           (g_set == SET_A && ch >= CH_AT));
    return ch;
  endfunction

  function automatic logic [7:0] gen_bad();
    logic [7:0] ch;
    do ch = $urandom_range(0, 255); while (char_ok(ch));
    return ch;
  endfunction

  function automatic void fill_text(int n);
    for (int i = 0; i < n; i++) begin
      if (g_set != SET_C && esc_usable() && $urandom_range(0, 5) == 0) begin
        word_buf.push_back({1'b0, g_esc});
        word_buf.push_back(gen_follow());
      end else begin
        word_buf.push_back(gen_plain());
      end
    end
  endfunction

  function automatic void flush(bit f, bit o, bit l);
    foreach (word_buf[i]) begin
      add_char(word_buf[i], f && i == 0, l && i == word_buf.size() - 1,
               (i == 0) ? o : $urandom_range(0, 1));
    end
    word_buf.delete();
  endfunction

  function automatic void add_good();
    int n;
    if (g_set == SET_C) begin
      n = $urandom_range(1, 10);
      fill_text(n);
      flush(1'b1, n % 2, 1'b1);
    end else begin
      fill_text($urandom_range(1, 8));
      flush(1'b1, $urandom_range(0, 1), 1'b1);
    end
  endfunction

  function automatic void add_broken();
    case ($urandom_range(0, 2))
      0: begin
        fill_text($urandom_range(0, 3));
        word_buf.push_back(gen_bad());
        fill_text($urandom_range(0, 3));
        flush(1'b1, $urandom_range(0, 1), 1'b1);
      end
      1: begin
        // The string ends with an escape open, a digit still held or, if no escape is usable, a bad character.
        if (g_set == SET_C) begin
          fill_text(2 * $urandom_range(0, 4) + 1);
        end else begin
          fill_text($urandom_range(0, 4));
          word_buf.push_back(esc_usable() ? {1'b0, g_esc} : gen_bad());
        end
        flush(1'b1, 1'b0, 1'b1);
      end
      default: begin
        if (g_set == SET_C) begin
          // Even digit count flagged odd leaves a digit held at the end.
          fill_text(2 * $urandom_range(1, 4));
          flush(1'b1, 1'b1, 1'b1);
        end else begin
          fill_text($urandom_range(0, 3));
          if (esc_usable()) begin
            word_buf.push_back({1'b0, g_esc});
            word_buf.push_back(gen_wrong_follow());
          end else begin
            word_buf.push_back(gen_bad());
          end
          fill_text($urandom_range(0, 3));
          flush(1'b1, 1'b0, 1'b1);
        end
      end
    endcase
  endfunction

  // A string that carries on without a first character.
  function automatic void add_headless();
    if (g_set == SET_C) fill_text(2 * $urandom_range(1, 4));
    else fill_text($urandom_range(1, 6));
    flush(1'b0, 1'b0, 1'b1);
  endfunction

  function automatic void fill_phase(int n);
    int stop_at;
    int pick;
    stop_at = queued_chars + n;
    while (queued_chars < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) add_good();
      else if (pick < 8) add_broken();
      else if (pick == 8) add_headless();
      else add_char($urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1),
                    $urandom_range(0, 1));
    end
  endfunction

  initial begin : build_stimulus
    m_set    = SET_C;
    m_check  = 1'b1;
    m_start  = 1'b1;
    m_escape = BACKSLASH[6:0];
    clear_string();
    g_set = SET_C;
    g_esc = BACKSLASH[6:0];

    // Set C after reset: extreme pairs, a lone odd digit, a bad digit, a held digit.
    add_char(CH_0, 1, 0, 0);
    add_char(CH_0, 0, 0, 0);
    add_char(CH_9, 0, 0, 1);
    add_char(CH_9, 0, 1, 0);
    add_char(8'h37, 1, 1, 1);
    add_char(8'h2F, 1, 0, 0);
    add_char(CH_5, 0, 0, 0);
    add_char(8'h3A, 0, 1, 0);
    add_char(8'h34, 1, 1, 0);

    // Set A: range ends, control codes, FNC1 and FNC4.
    setup(SET_A, 1, 1, BACKSLASH[6:0]);
    add_char(CH_SPACE, 1, 0, 1);
    add_char(BACKSLASH, 0, 0, 0);
    add_char(CH_AT, 0, 0, 0);
    add_char(BACKSLASH, 0, 0, 0);
    add_char(CH_TOP_A, 0, 0, 0);
    add_char(BACKSLASH, 0, 0, 0);
    add_char(CH_1, 0, 0, 0);
    add_char(BACKSLASH, 0, 0, 0);
    add_char(CH_4, 0, 0, 0);
    add_char(CH_TOP_A, 0, 1, 0);

    // Set B without start or check: DEL, FNC2, FNC3, then an invalid last character.
    setup(SET_B, 0, 0, BACKSLASH[6:0]);
    add_char(CH_TOP_B, 1, 0, 0);
    add_char(BACKSLASH, 0, 0, 0);
    add_char(CH_5, 0, 0, 0);
    add_char(BACKSLASH, 0, 0, 0);
    add_char(CH_2, 0, 0, 0);
    add_char(BACKSLASH, 0, 0, 0);
    add_char(CH_3, 0, 0, 0);
    add_char(8'hFF, 0, 1, 1);

    setup(SET_C, 1, 1, $urandom_range(32, 126));
    add_job(JOB_HOLD, '0, '0);
    fill_phase(35);

    setup(SET_A, 0, 1, $urandom_range(32, 95));
    fill_phase(20);
    add_job(JOB_DRAIN, '0, '0);
    fill_phase(20);

    setup(SET_B, 1, 0, 7'd126);
    fill_phase(30);

    // One string long enough for the weights to wrap.
    setup(SET_B, 1, 1, $urandom_range(32, 126));
    for (int i = 0; i < 104; i++) word_buf.push_back(gen_plain());
    flush(1'b1, 1'b0, 1'b1);
    fill_phase(6);

    setup(SET_A, 1, 0, 7'd32);
    add_job(JOB_HOLD, '0, '0);
    fill_phase(30);

    setup(SET_NONE, 1, 1, BACKSLASH[6:0]);
    fill_phase(8);

    setup(SET_C, 0, 0, BACKSLASH[6:0]);
    fill_phase(30);

    setup(SET_B, 1, 1, BACKSLASH[6:0]);
    add_job(JOB_CALM, '0, '0);
    fill_phase(25);
  end

  // ---------------------------------------------------------------- clock, reset

  initial begin
    char_bus.valid      = 1'b0;
    char_bus.data_char  = '0;
    char_bus.first_char = 1'b0;
    char_bus.last_char  = 1'b0;
    char_bus.odd_length = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.addr        = '0;
    cfg_bus.wdata       = '0;
    sym_bus.ready       = 1'b0;
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      char_bus.valid <= 1'b0;
      cfg_bus.valid  <= 1'b0;
      gap_left   = 0;
      settle_cnt = 0;
    end else begin
      char_on = char_bus.valid;
      cfg_on  = cfg_bus.valid;
      if (char_bus.valid && char_bus.ready) begin
        encode_char(cur_char);
        n_chars++;
        char_on = 1'b0;
        if (!calm && (n_chars % 64) < 40 && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 10);
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        load_register(cur_cfg.reg_idx, cur_cfg.reg_val);
        n_writes++;
        cfg_on = 1'b0;
      end
      if (!char_on && !cfg_on) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (jobs.size() == 0) begin
          all_sent <= 1'b1;
        end else begin
          case (jobs[0].kind)
            JOB_CHAR: begin
              cur_job  = jobs.pop_front();
              cur_char = cur_job.c;
              char_bus.data_char  <= cur_char.ch;
              char_bus.first_char <= cur_char.first_char;
              char_bus.last_char  <= cur_char.last_char;
              char_bus.odd_length <= cur_char.odd_length;
              char_on = 1'b1;
            end
            JOB_CFG: begin
              cur_cfg = jobs.pop_front();
              cfg_bus.addr  <= cur_cfg.reg_idx;
              cfg_bus.wdata <= cur_cfg.reg_val;
              cfg_on = 1'b1;
            end
            JOB_DRAIN: begin
              // Characters that owe nothing may still be in flight, so wait a while.
              if (owed_symbols.size() != 0) settle_cnt = 0;
              else settle_cnt++;
              if (settle_cnt >= SETTLE) begin
                settle_cnt = 0;
                jobs.delete(0);
              end
            end
            JOB_HOLD: begin
              jobs.delete(0);
              hold_req <= !hold_req;
            end
            default: begin
              jobs.delete(0);
              calm <= 1'b1;
            end
          endcase
        end
      end
      char_bus.valid <= char_on;
      cfg_bus.valid  <= cfg_on;
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (rst) begin
      sym_bus.ready <= 1'b0;
      stall_left = 0;
      rx_cycle   = '0;
    end else begin
      rx_open = 1'b1;
      if (hold_req != hold_ack) begin
        hold_ack   = hold_req;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        rx_open = 1'b0;
      end else if (!calm && rx_cycle[7] && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        rx_open = 1'b0;
      end
      sym_bus.ready <= rx_open;
      rx_cycle++;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (!rst && sym_bus.valid && sym_bus.ready) begin
      if (owed_symbols.size() == 0) begin
        $error("symbol %0d arrived with nothing owed", sym_bus.symbol_value);
        fail_count++;
      end else begin
        want = owed_symbols.pop_front();
        n_checked++;
        if (sym_bus.error_flag) n_err_seen++;
        if (sym_bus.symbol_value !== want.sym) begin
          $error("symbol_value: expected %0d, got %0d", want.sym, sym_bus.symbol_value);
          fail_count++;
        end
        if (sym_bus.bar_widths !== want.bars) begin
          $error("bar_widths: expected %h, got %h", want.bars, sym_bus.bar_widths);
          fail_count++;
        end
        if (sym_bus.width_count !== want.count) begin
          $error("width_count: expected %0d, got %0d", want.count, sym_bus.width_count);
          fail_count++;
        end
        if (sym_bus.error_flag !== want.err) begin
          $error("error_flag: expected %0d, got %0d", want.err, sym_bus.error_flag);
          fail_count++;
        end
        if (sym_bus.end_of_symbol !== want.eos) begin
          $error("end_of_symbol: expected %0d, got %0d", want.eos, sym_bus.end_of_symbol);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- end of run

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : finish_run
    int leftover;
    wait (all_sent === 1'b1);
    while (owed_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    leftover = owed_symbols.size();
    if (leftover != 0) $error("%0d symbols still owed at the end", leftover);
    $display("Sent %0d characters and %0d register writes across sets A, B, C and the unused code.",
             n_chars, n_writes);
    $display("Checked %0d symbols, %0d of them error results.", n_checked, n_err_seen);
    if (fail_count == 0 && leftover == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
